// ----- rtl/core/ppq_pkg.sv -----
`default_nettype none

package ppq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int ID_W        = 5;
    localparam int PRIO_W      = 8;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_COUNT_W = 6;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    localparam logic [CMD_W-1:0] CMD_INSERT      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE_HEAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_ID   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK        = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] OP_HOLD      = 2'd0;
    localparam logic [1:0] OP_INSERT    = 2'd1;
    localparam logic [1:0] OP_SHIFT_ALL = 2'd2;
    localparam logic [1:0] OP_REMOVE_ID = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     req;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/ppq_cell.sv -----
`default_nettype none

module ppq_cell
    import ppq_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       before_hit,
    input  wire logic       left_ins,
    input  wire entry_t     left_entry,
    input  wire entry_t     right_entry,
    output entry_t          entry,
    output logic            ins_here,
    output logic            match
);

    entry_t entry_reg;
    entry_t entry_next;

    assign entry    = entry_reg;
    assign ins_here = !occupied || (ctrl.req.prio > entry_reg.prio);
    assign match    = occupied && (entry_reg.id == ctrl.req.id);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            OP_INSERT:
            begin
                if (left_ins)
                begin
                    entry_next = left_entry;
                end
                else if (ins_here)
                begin
                    entry_next = ctrl.req;
                end
            end
            OP_SHIFT_ALL:
            begin
                entry_next = right_entry;
            end
            OP_REMOVE_ID:
            begin
                if (before_hit || match)
                begin
                    entry_next = right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/process_priority_queue.sv -----
`default_nettype none

// Channel   Direction  Payload (tdata, low bit first)
// s_axis    in         command[1:0], process_id[6:2], priority_req[14:7], zero[15]
// m_axis    out        status[1:0], result_id[6:2], result_priority[14:7],
//                      is_empty[15], entry_count[21:16], zero[23:22]
//
// One transaction per cycle: every cell of the sorted chain compares against the
// request in parallel and shifts or loads in the same cycle; the result appears
// in the output register on the next cycle. rst_n clears the fill count and the
// output valid. A stalled output holds s_axis_tready low only while its register
// is full and m_axis_tready is low.

module process_priority_queue
    import ppq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // command, process_id, priority_req
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // status, result_id, result_priority,
                                                      // is_empty, entry_count
);

    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic [CMD_W-1:0]      cmd;
    entry_t                req;
    cell_ctrl_t            ctrl;
    logic                  accept;

    entry_t                cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_ins;
    logic [QUEUE_DEPTH-1:0] cell_match;
    logic [QUEUE_DEPTH-1:0] cell_occupied;
    logic [QUEUE_DEPTH-1:0] cell_before;

    logic                  empty;
    logic                  full;
    logic                  found;
    entry_t                hit_entry;
    entry_t                head_after_ins;
    logic [STATUS_W-1:0]   res_status;
    entry_t                res_entry;

    assign cmd      = s_axis_tdata[CMD_W-1:0];
    assign req.id   = s_axis_tdata[CMD_W +: ID_W];
    assign req.prio = s_axis_tdata[CMD_W+ID_W +: PRIO_W];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign found = |cell_match;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_i;
            logic   before_i;

            assign cell_occupied[k] = (COUNT_W'(k) < count_reg);

            if (k == 0)
            begin : g_first
                assign left_e   = cell_entry[0];
                assign left_i   = 1'b0;
                assign before_i = 1'b0;
            end
            else
            begin : g_rest
                assign left_e   = cell_entry[k-1];
                assign left_i   = cell_ins[k-1];
                assign before_i = |cell_match[k-1:0];
            end

            if (k == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[k];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[k+1];
            end

            assign cell_before[k] = before_i;

            ppq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (cell_occupied[k]),
                .before_hit  (before_i),
                .left_ins    (left_i),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[k]),
                .ins_here    (cell_ins[k]),
                .match       (cell_match[k])
            );
        end
    endgenerate

    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (cell_match[i] && !cell_before[i])
            begin
                hit_entry = hit_entry | cell_entry[i];
            end
        end
    end

    assign head_after_ins = cell_ins[0] ? req : cell_entry[0];

    always_comb
    begin
        ctrl.req   = req;
        ctrl.op    = OP_HOLD;
        count_next = count_reg;
        res_status = STATUS_OK;
        res_entry  = '0;
        unique case (cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    res_status = STATUS_FULL;
                end
                else
                begin
                    ctrl.op    = OP_INSERT;
                    count_next = count_reg + COUNT_W'(1);
                    res_entry  = head_after_ins;
                end
            end
            CMD_REMOVE_HEAD:
            begin
                if (empty)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    ctrl.op    = OP_SHIFT_ALL;
                    count_next = count_reg - COUNT_W'(1);
                    res_entry  = cell_entry[0];
                end
            end
            CMD_REMOVE_ID:
            begin
                if (!found)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    ctrl.op    = OP_REMOVE_ID;
                    count_next = count_reg - COUNT_W'(1);
                    res_entry  = hit_entry;
                end
            end
            CMD_PEEK:
            begin
                if (empty)
                begin
                    res_status = STATUS_EMPTY;
                end
                else
                begin
                    res_entry = cell_entry[0];
                end
            end
            default:
            begin
                res_status = STATUS_EMPTY;
            end
        endcase
        if (!accept)
        begin
            ctrl.op    = OP_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[STATUS_W-1:0]                    = res_status;
        out_data_next[STATUS_W +: ID_W]                = res_entry.id;
        out_data_next[STATUS_W+ID_W +: PRIO_W]         = res_entry.prio;
        out_data_next[STATUS_W+ID_W+PRIO_W]            = (count_next == '0);
        out_data_next[STATUS_W+ID_W+PRIO_W+1 +: OUT_COUNT_W] =
            OUT_COUNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ppq_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int LONG_HOLD    = 200;
    localparam int END_SETTLE   = 8;
    localparam int TIMEOUT_NS   = 4_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [ID_W-1:0]        id;
        logic [PRIO_W-1:0]      prio;
        logic                   empty;
        logic [OUT_COUNT_W-1:0] count;
    } queue_answer_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        logic              typed;
        queue_answer_t     ans;
    } directed_row_t;

    localparam queue_answer_t NO_ANSWER = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [ID_W-1:0]   ready_ids   [QUEUE_DEPTH];
    logic [PRIO_W-1:0] ready_prios [QUEUE_DEPTH];
    int                ready_count = 0;

    queue_answer_t pending_answers [$];
    int            mismatch_count = 0;
    int            sink_wait = 0;
    bit            long_hold_req = 1'b0;
    bit            no_idle = 1'b0;

    directed_row_t directed_table [17] = '{
        '{CMD_PEEK,        5'd0,  8'd0,   1'b1, '{STATUS_EMPTY, 5'd0,  8'd0,   1'b1, 6'd0}},
        '{CMD_REMOVE_HEAD, 5'd0,  8'd0,   1'b1, '{STATUS_EMPTY, 5'd0,  8'd0,   1'b1, 6'd0}},
        '{CMD_REMOVE_ID,   5'd5,  8'd0,   1'b1, '{STATUS_EMPTY, 5'd0,  8'd0,   1'b1, 6'd0}},
        '{CMD_INSERT,      5'd31, 8'd255, 1'b1, '{STATUS_OK,    5'd31, 8'd255, 1'b0, 6'd1}},
        '{CMD_INSERT,      5'd0,  8'd0,   1'b1, '{STATUS_OK,    5'd31, 8'd255, 1'b0, 6'd2}},
        '{CMD_INSERT,      5'd7,  8'd255, 1'b0, NO_ANSWER},
        '{CMD_PEEK,        5'd0,  8'd0,   1'b0, NO_ANSWER},
        '{CMD_REMOVE_ID,   5'd7,  8'd0,   1'b0, NO_ANSWER},
        '{CMD_REMOVE_ID,   5'd9,  8'd0,   1'b1, '{STATUS_EMPTY, 5'd0,  8'd0,   1'b0, 6'd2}},
        '{CMD_INSERT,      5'd31, 8'd100, 1'b0, NO_ANSWER},
        '{CMD_REMOVE_ID,   5'd31, 8'd0,   1'b0, NO_ANSWER},
        '{CMD_REMOVE_HEAD, 5'd0,  8'd0,   1'b0, NO_ANSWER},
        '{CMD_REMOVE_HEAD, 5'd0,  8'd0,   1'b0, NO_ANSWER},
        '{CMD_REMOVE_HEAD, 5'd0,  8'd0,   1'b1, '{STATUS_EMPTY, 5'd0,  8'd0,   1'b1, 6'd0}},
        '{CMD_INSERT,      5'd16, 8'd128, 1'b1, '{STATUS_OK,    5'd16, 8'd128, 1'b0, 6'd1}},
        '{CMD_PEEK,        5'd0,  8'd0,   1'b1, '{STATUS_OK,    5'd16, 8'd128, 1'b0, 6'd1}},
        '{CMD_REMOVE_ID,   5'd16, 8'd0,   1'b1, '{STATUS_OK,    5'd16, 8'd128, 1'b1, 6'd0}}
    };

    process_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // command, process_id, priority_req
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // status, result_id, result_priority,
                                         // is_empty, entry_count
    );

    always #10 clk = ~clk;

    function automatic queue_answer_t apply_command(input logic [CMD_W-1:0]  cmd,
                                                    input logic [ID_W-1:0]   pid,
                                                    input logic [PRIO_W-1:0] prio);
        queue_answer_t ans;
        int            slot;
        ans = '0;
        slot = -1;
        if (cmd == CMD_INSERT) begin
            if (ready_count >= QUEUE_DEPTH) begin
                ans.status = STATUS_FULL;
            end
            else begin
                slot = ready_count;
                for (int k = 0; k < ready_count; k++) begin
                    if (prio > ready_prios[k] && slot == ready_count) slot = k;
                end
                for (int k = ready_count; k > slot; k--) begin
                    ready_ids[k]   = ready_ids[k-1];
                    ready_prios[k] = ready_prios[k-1];
                end
                ready_ids[slot]   = pid;
                ready_prios[slot] = prio;
                ready_count++;
                ans.status = STATUS_OK;
                ans.id     = ready_ids[0];
                ans.prio   = ready_prios[0];
            end
        end
        else if (ready_count == 0) begin
            ans.status = STATUS_EMPTY;
        end
        else if (cmd == CMD_PEEK) begin
            ans.status = STATUS_OK;
            ans.id     = ready_ids[0];
            ans.prio   = ready_prios[0];
        end
        else begin
            if (cmd == CMD_REMOVE_HEAD) slot = 0;
            else begin
                for (int k = 0; k < ready_count; k++) begin
                    if (ready_ids[k] == pid && slot < 0) slot = k;
                end
            end
            if (slot < 0) begin
                ans.status = STATUS_EMPTY;
            end
            else begin
                ans.status = STATUS_OK;
                ans.id     = ready_ids[slot];
                ans.prio   = ready_prios[slot];
                for (int k = slot; k + 1 < ready_count; k++) begin
                    ready_ids[k]   = ready_ids[k+1];
                    ready_prios[k] = ready_prios[k+1];
                end
                ready_count--;
            end
        end
        ans.empty = (ready_count == 0);
        ans.count = OUT_COUNT_W'(ready_count);
        return ans;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned seen_v,
                                 input int unsigned due_v);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, seen_v, due_v);
        mismatch_count++;
    endtask

    task automatic issue_command(input logic [CMD_W-1:0]  cmd,
                                 input logic [ID_W-1:0]   pid,
                                 input logic [PRIO_W-1:0] prio,
                                 input bit                typed,
                                 input queue_answer_t     typed_ans);
        int            gap;
        queue_answer_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, prio, pid, cmd};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        predicted = apply_command(cmd, pid, prio);
        pending_answers.push_back(typed ? typed_ans : predicted);
    endtask

    task automatic wait_for_answers();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
    endtask

    // Hold the receiver for each transaction, or for a long stretch on request.
    initial begin : result_sink
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                sink_wait = LONG_HOLD;
            end
            if (sink_wait > 0) begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        queue_answer_t seen;
        queue_answer_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.status = m_axis_tdata[1:0];
            seen.id     = m_axis_tdata[6:2];
            seen.prio   = m_axis_tdata[14:7];
            seen.empty  = m_axis_tdata[15];
            seen.count  = m_axis_tdata[21:16];
            if (pending_answers.size() == 0) begin
                flag_mismatch("unexpected transaction status", seen.status, 0);
            end
            else begin
                due = pending_answers.pop_front();
                if (seen.status !== due.status) flag_mismatch("status", seen.status, due.status);
                if (seen.id !== due.id) flag_mismatch("result_id", seen.id, due.id);
                if (seen.prio !== due.prio)
                    flag_mismatch("result_priority", seen.prio, due.prio);
                if (seen.empty !== due.empty) flag_mismatch("is_empty", seen.empty, due.empty);
                if (seen.count !== due.count)
                    flag_mismatch("entry_count", seen.count, due.count);
            end
            sink_wait = no_idle ? 0 : $urandom_range(0, 10);
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        int                sent;
        int                seg_len;
        int                insert_pct;
        int                prio_style;
        int                pick;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_table[i]) begin
            issue_command(directed_table[i].cmd, directed_table[i].pid, directed_table[i].prio,
                          directed_table[i].typed, directed_table[i].ans);
        end
        wait_for_answers();

        // Fill past capacity while the receiver stalls.
        no_idle = 1'b1;
        long_hold_req = 1'b1;
        for (int n = 0; n <= QUEUE_DEPTH; n++) begin
            issue_command(CMD_INSERT, ID_W'($urandom_range(0, 31)),
                          PRIO_W'($urandom_range(0, 255)), 1'b0, NO_ANSWER);
        end
        wait_for_answers();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 50);
            case ($urandom_range(0, 2))
                0:       insert_pct = 25;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            prio_style = $urandom_range(0, 2);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < seg_len; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < insert_pct) cmd = CMD_INSERT;
                else begin
                    case ($urandom_range(0, 2))
                        0:       cmd = CMD_REMOVE_HEAD;
                        1:       cmd = CMD_REMOVE_ID;
                        default: cmd = CMD_PEEK;
                    endcase
                end
                pid = ID_W'($urandom_range(0, 31));
                if (cmd == CMD_REMOVE_ID && ready_count > 0 && $urandom_range(0, 9) < 7)
                    pid = ready_ids[$urandom_range(0, ready_count - 1)];
                case (prio_style)
                    0: prio = PRIO_W'($urandom_range(0, 255));
                    1: begin
                        pick = $urandom_range(0, 3);
                        prio = PRIO_W'((pick < 2) ? pick : 252 + pick);
                    end
                    default: prio = PRIO_W'($urandom_range(100, 103));
                endcase
                issue_command(cmd, pid, prio, 1'b0, NO_ANSWER);
            end
            sent += seg_len;
            if ($urandom_range(0, 2) == 0) wait_for_answers();
        end

        wait_for_answers();
        repeat (END_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("process_priority_queue test passed");
        else
            $display("process_priority_queue test failed");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("process_priority_queue test failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/ppq_pkg.sv
rtl/core/ppq_cell.sv
rtl/core/process_priority_queue.sv
dv/testbench.sv
